// ===== rtl/cts_pkg.sv =====
// Shared types, constants and reciprocal table for the cosine Taylor-series block.
package cts_pkg;

	localparam int FRAC_BITS = 28;
	localparam int MAX_TERMS = 16;
	localparam int TERM_W    = $clog2(MAX_TERMS);

	localparam int X_W     = 32;
	localparam int CNT_W   = 5;
	localparam int SUM_W   = 48;
	localparam int MAG_W   = SUM_W - 1;
	localparam int RECIP_W = 32;
	localparam int RECIP_SH = RECIP_W;

	// Shared multiplier: operand A is taken one digit per cycle, operand B whole.
	localparam int DIG_W = 24;
	localparam int A_W   = 2 * DIG_W;
	localparam int B_W   = 36;
	localparam int PP_W  = DIG_W + B_W;
	localparam int ACC_W = A_W + B_W;

	// round-half-up(2^32 / ((2i-1)(2i))), entry 0 unused
	localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_TERMS] = '{
		32'd0,        32'd2147483648, 32'd357913941, 32'd143165577,
		32'd76695845, 32'd47721859,   32'd32537631,  32'd23598721,
		32'd17895697, 32'd14035841,   32'd11302546,  32'd9296466,
		32'd7780738,  32'd6607642,    32'd5681174,   32'd4936744
	};

	typedef struct packed {
		logic signed [X_W-1:0] angle_x;
		logic [CNT_W-1:0]      term_count;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] cos_sum;
		logic                    sum_saturated;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic hi;
	} mul_cmd_t;

endpackage

// ===== rtl/cts_mac.sv =====
// Shared digit-serial multiply-accumulate unit: 24 x 36 product per cycle while cmd.en is set.
module cts_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cts_pkg::mul_cmd_t          cmd,
	input  logic [cts_pkg::A_W-1:0]    a,
	input  logic [cts_pkg::B_W-1:0]    b,
	output logic [cts_pkg::ACC_W-1:0]  acc
);

	logic [cts_pkg::DIG_W-1:0] dig;
	logic [cts_pkg::PP_W-1:0]  pp;
	logic [cts_pkg::ACC_W-1:0] acc_q;
	logic [cts_pkg::ACC_W-1:0] acc_nxt;

	always_comb begin
		dig = cmd.hi ? a[cts_pkg::A_W-1:cts_pkg::DIG_W] : a[cts_pkg::DIG_W-1:0];
		pp  = cts_pkg::PP_W'(dig) * cts_pkg::PP_W'(b);
		// low digit starts a fresh product, high digit adds in at its weight
		if (cmd.hi) begin
			acc_nxt = acc_q + (cts_pkg::ACC_W'(pp) << cts_pkg::DIG_W);
		end else begin
			acc_nxt = cts_pkg::ACC_W'(pp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.en) begin
			acc_q <= acc_nxt;
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/cts_core.sv =====
// Sequencer and term/sum datapath around the shared multiply-accumulate unit.
module cts_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 idle,
	input  cts_pkg::in_item_t    item,
	output logic                 res_valid,
	input  logic                 res_take,
	output cts_pkg::out_item_t   res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MLO,
		S_MHI,
		S_NORM,
		S_ADD,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_SQ,
		OP_TX,
		OP_TR
	} op_t;

	state_t                        state_q;
	op_t                           op_q;
	logic [cts_pkg::A_W-1:0]       a_q;
	logic [cts_pkg::B_W-1:0]       b_q;
	logic [cts_pkg::B_W-1:0]       x2_q;
	logic [cts_pkg::MAG_W-1:0]     mag_q;
	logic [cts_pkg::SUM_W-1:0]     sum_q;
	logic                          clip_q;
	logic [cts_pkg::TERM_W-1:0]    i_q;
	logic [cts_pkg::CNT_W-1:0]     cnt_q;

	cts_pkg::mul_cmd_t             cmd;
	logic [cts_pkg::ACC_W-1:0]     acc;

	logic [cts_pkg::X_W-1:0]       xm;
	logic [cts_pkg::CNT_W-1:0]     cnt_in;
	logic                          tx_ovf;
	logic                          tr_ovf;
	logic [cts_pkg::MAG_W-1:0]     mag_tx;
	logic [cts_pkg::MAG_W-1:0]     mag_tr;
	logic [cts_pkg::SUM_W:0]       sum_ext;
	logic [cts_pkg::SUM_W:0]       term_ext;
	logic [cts_pkg::SUM_W:0]       sum_raw;
	logic                          sum_ovf;
	logic [cts_pkg::SUM_W-1:0]     sum_sat;
	logic                          last_term;

	cts_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (a_q),
		.b      (b_q),
		.acc    (acc)
	);

	always_comb begin
		cmd.en = (state_q == S_MLO) || (state_q == S_MHI);
		cmd.hi = (state_q == S_MHI);

		xm = item.angle_x[cts_pkg::X_W-1] ? (~item.angle_x + 1'b1) : item.angle_x;
		if (item.term_count > cts_pkg::CNT_W'(cts_pkg::MAX_TERMS)) begin
			cnt_in = cts_pkg::CNT_W'(cts_pkg::MAX_TERMS);
		end else begin
			cnt_in = item.term_count;
		end

		// scale back and clip the finished product
		tx_ovf = |acc[cts_pkg::ACC_W-1:cts_pkg::FRAC_BITS+cts_pkg::MAG_W];
		mag_tx = tx_ovf ? '1 : acc[cts_pkg::FRAC_BITS +: cts_pkg::MAG_W];
		tr_ovf = |acc[cts_pkg::ACC_W-1:cts_pkg::RECIP_SH+cts_pkg::MAG_W];
		mag_tr = tr_ovf ? '1 : acc[cts_pkg::RECIP_SH +: cts_pkg::MAG_W];

		// odd terms subtract
		sum_ext  = {sum_q[cts_pkg::SUM_W-1], sum_q};
		term_ext = {2'b00, mag_q};
		sum_raw  = i_q[0] ? (sum_ext - term_ext) : (sum_ext + term_ext);
		sum_ovf  = sum_raw[cts_pkg::SUM_W] ^ sum_raw[cts_pkg::SUM_W-1];
		if (!sum_ovf) begin
			sum_sat = sum_raw[cts_pkg::SUM_W-1:0];
		end else if (sum_raw[cts_pkg::SUM_W]) begin
			sum_sat = {1'b1, {(cts_pkg::SUM_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(cts_pkg::SUM_W-1){1'b1}}};
		end

		last_term = (cts_pkg::CNT_W'(i_q) + cts_pkg::CNT_W'(1)) == cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_SQ;
			a_q     <= '0;
			b_q     <= '0;
			x2_q    <= '0;
			mag_q   <= '0;
			sum_q   <= '0;
			clip_q  <= 1'b0;
			i_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						a_q    <= cts_pkg::A_W'(xm);
						b_q    <= cts_pkg::B_W'(xm);
						op_q   <= OP_SQ;
						cnt_q  <= cnt_in;
						i_q    <= '0;
						clip_q <= 1'b0;
						mag_q  <= cts_pkg::MAG_W'(1) << cts_pkg::FRAC_BITS;
						// term 0 is exactly 1.0
						if (cnt_in == '0) begin
							sum_q <= '0;
						end else begin
							sum_q <= cts_pkg::SUM_W'(1) << cts_pkg::FRAC_BITS;
						end
						state_q <= S_MLO;
					end
				end
				S_MLO: begin
					state_q <= S_MHI;
				end
				S_MHI: begin
					state_q <= S_NORM;
				end
				S_NORM: begin
					unique case (op_q)
						OP_SQ: begin
							x2_q <= acc[cts_pkg::FRAC_BITS +: cts_pkg::B_W];
							if (cnt_q <= cts_pkg::CNT_W'(1)) begin
								state_q <= S_DONE;
							end else begin
								a_q     <= cts_pkg::A_W'(mag_q);
								b_q     <= acc[cts_pkg::FRAC_BITS +: cts_pkg::B_W];
								i_q     <= cts_pkg::TERM_W'(1);
								op_q    <= OP_TX;
								state_q <= S_MLO;
							end
						end
						OP_TX: begin
							clip_q  <= clip_q | tx_ovf;
							a_q     <= cts_pkg::A_W'(mag_tx);
							b_q     <= cts_pkg::B_W'(cts_pkg::RECIP_TAB[i_q]);
							op_q    <= OP_TR;
							state_q <= S_MLO;
						end
						default: begin
							clip_q  <= clip_q | tr_ovf;
							mag_q   <= mag_tr;
							state_q <= S_ADD;
						end
					endcase
				end
				S_ADD: begin
					sum_q  <= sum_sat;
					clip_q <= clip_q | sum_ovf;
					if (last_term) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						a_q     <= cts_pkg::A_W'(mag_q);
						b_q     <= x2_q;
						op_q    <= OP_TX;
						state_q <= S_MLO;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle              = (state_q == S_IDLE);
	assign res_valid         = (state_q == S_DONE);
	assign res.cos_sum       = sum_q;
	assign res.sum_saturated = clip_q;

endmodule

// ===== rtl/cosine_taylor_partial_sum.sv =====
// Top level of the fixed-point cosine partial Maclaurin sum with output register.
//
// Computes sum over i = 0 .. n-1 of (-1)^i x^(2i)/(2i)! for a Q4.28 argument
// and a term count n (counts above 16 act as 16, zero gives 0). Each term is
// built from the last one as term * x^2 * 1/((2i-1)(2i)), with the reciprocal
// taken from a constant table, and the Q20.28 sum clips to 48 bits; the
// sum_saturated bit reports any clip of a term or the sum. All products go
// through one shared 24 x 36 multiply-accumulate unit, low digit then high
// digit, so x^2 takes the states MLO, MHI and NORM, and every term after the
// first takes two products, their scaling and one add. in_ready stays low
// while an item occupies the sequencer. The finished result moves into an
// output register, so the next item can be taken while a result still waits
// on out_ready.
module cosine_taylor_partial_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cts_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cts_pkg::out_item_t   out_data
);

	logic                 core_idle;
	logic                 res_valid;
	logic                 res_take;
	cts_pkg::out_item_t   res;
	logic                 out_valid_q;
	cts_pkg::out_item_t   out_data_q;

	// accept a beat whenever the sequencer is free
	assign in_ready = core_idle;

	// the output slot frees up when empty or when its beat leaves this cycle
	assign res_take = !out_valid_q || out_ready;

	cts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && core_idle),
		.idle      (core_idle),
		.item      (in_data),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// hold the result until taken, load the next one when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
			out_data_q  <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/cts_checker.sv =====
// Port-level checker for the cosine partial-sum block and its bind.
module cts_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  cts_pkg::in_item_t    in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  cts_pkg::out_item_t   out_data
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// track beats taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while waiting");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pend_q != 2'd0))
		else $error("result delivered with no item outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more items outstanding than the block can hold");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while previous item in work");

endmodule

bind cosine_taylor_partial_sum cts_checker u_cts_checker (.*);

// ===== verif/cosine_sum_checker.sv =====
// Scoreboard for the cosine partial-sum block: predicts every result and compares it.
`timescale 1ns / 100ps

module cosine_sum_checker
	import cts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        mismatches,
	output int        pending,
	output int        checked
);

	localparam logic [63:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;
	localparam longint      SUM_HI  = longint'(MAG_MAX);
	localparam longint      SUM_LO  = -SUM_HI - 64'sd1;
	localparam int          SHOW_MAX = 50;

	typedef struct packed {
		in_item_t  stim;
		out_item_t want;
	} cos_expect_t;

	cos_expect_t expected_sums [$];
	int err_count  = 0;
	int seen_count = 0;
	int depth      = 0;

	assign mismatches = err_count;
	assign pending    = depth;
	assign checked    = seen_count;

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= SHOW_MAX)
			$display("%0t cosine_sum_checker: %s", $time, msg);
	endtask

	// floor(a*b / 2^sh), clipped to the term magnitude limit
	function automatic logic [63:0] scale_sat(input logic [63:0] a, input logic [63:0] b,
			input int sh, inout logic clipped);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> sh;
		if (prod > {64'd0, MAG_MAX}) begin
			clipped = 1'b1;
			return MAG_MAX;
		end
		return prod[63:0];
	endfunction

	function automatic out_item_t predict_cosine(input in_item_t item);
		logic [63:0] x_raw;
		logic [63:0] x_mag;
		logic [63:0] x_sq;
		logic [63:0] mag;
		logic [63:0] den;
		logic [63:0] recip;
		longint      acc;
		int          terms;
		int          i;
		logic        clipped;
		out_item_t   res;
		x_raw = {32'd0, item.angle_x};
		x_mag = item.angle_x[X_W-1] ? ((64'd1 << X_W) - x_raw) : x_raw;
		x_sq  = (x_mag * x_mag) >> FRAC_BITS;
		terms = (item.term_count > MAX_TERMS) ? MAX_TERMS : int'(item.term_count);
		mag     = 64'd1 << FRAC_BITS;
		acc     = 0;
		clipped = 1'b0;
		for (i = 0; i < terms; i++) begin
			if (i > 0) begin
				den   = 64'(2 * i - 1) * 64'(2 * i);
				recip = ((64'd1 << RECIP_SH) + den / 2) / den;
				mag   = scale_sat(mag, x_sq, FRAC_BITS, clipped);
				mag   = scale_sat(mag, recip, RECIP_SH, clipped);
			end
			acc += (i % 2 == 1) ? -longint'(mag) : longint'(mag);
			if (acc > SUM_HI) begin
				acc     = SUM_HI;
				clipped = 1'b1;
			end else if (acc < SUM_LO) begin
				acc     = SUM_LO;
				clipped = 1'b1;
			end
		end
		res.cos_sum       = acc[SUM_W-1:0];
		res.sum_saturated = clipped;
		return res;
	endfunction

	always @(posedge clk) begin : watch
		cos_expect_t exp_item;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				exp_item.stim = in_data;
				exp_item.want = predict_cosine(in_data);
				expected_sums.push_back(exp_item);
			end
			if (out_valid && out_ready) begin
				seen_count++;
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat: cos_sum=%0d sat=%0b",
						out_data.cos_sum, out_data.sum_saturated));
				end else begin
					exp_item = expected_sums.pop_front();
					if (out_data.cos_sum !== exp_item.want.cos_sum)
						report_mismatch($sformatf("x=%0d n=%0d cos_sum got %0d want %0d",
							exp_item.stim.angle_x, exp_item.stim.term_count,
							out_data.cos_sum, exp_item.want.cos_sum));
					if (out_data.sum_saturated !== exp_item.want.sum_saturated)
						report_mismatch($sformatf("x=%0d n=%0d sum_saturated got %b want %b",
							exp_item.stim.angle_x, exp_item.stim.term_count,
							out_data.sum_saturated, exp_item.want.sum_saturated));
				end
			end
			depth <= expected_sums.size();
		end
	end

endmodule

// ===== verif/tb_cosine_taylor_partial_sum.sv =====
// Testbench top for the cosine partial-sum block: stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module tb_cosine_taylor_partial_sum;
	import cts_pkg::*;

	// Watchdog limit, with a wide margin over the slowest items and the longest
	// gaps and stalls of a full run.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Long enough for the sequencer and the output register to fill and stall input.
	localparam int LONG_HOLD   = 800;
	// Drain margin after the last expected result, above one full 16-term item.
	localparam int TAIL_CYCLES = 150;

	localparam logic [X_W-1:0] X_ONE     = 32'h1000_0000;
	localparam logic [X_W-1:0] X_PI      = 32'd843314857;
	localparam logic [X_W-1:0] X_HALF_PI = 32'd421657428;
	localparam logic [X_W-1:0] X_MAX     = 32'h7FFF_FFFF;
	localparam logic [X_W-1:0] X_MIN     = 32'h8000_0000;

	logic      clk      = 1'b0;
	logic      arst_n   = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data  = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int mismatches;
	int pending;
	int checked;

	// Handshake flags between stimulus and the output-side process.
	bit stall_burst  = 1'b0;
	bit burst_active = 1'b0;
	bit burst_served = 1'b0;
	bit no_idle      = 1'b0;

	int cycle_count = 0;
	int beats_sent  = 0;
	int zero_counts = 0;
	int over_counts = 0;

	cosine_taylor_partial_sum uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	cosine_sum_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a hung run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_cosine_taylor_partial_sum: done, errors");
		$finish;
	end

	// Mostly short gaps, some medium, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t mk_item(input logic [X_W-1:0] x, input int n);
		in_item_t item;
		item.angle_x    = x;
		item.term_count = n[CNT_W-1:0];
		return item;
	endfunction

	// Weight angles toward the useful range around +-pi, but keep full 32-bit
	// noise so every bit toggles, and push some values to the ends of the range.
	function automatic logic [X_W-1:0] rand_angle();
		int            sel;
		logic [X_W-1:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			v = $urandom();
		else if (sel < 70)
			v = $urandom_range(0, X_PI);
		else if (sel < 85)
			v = $urandom_range(0, 255);
		else
			v = X_MAX - $urandom_range(0, 4095);
		if (sel >= 40 && $urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// Counts: mostly 1..16, a share at the full 16, plus zero and over-range ones.
	function automatic in_item_t rand_item();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 10)
			n = 0;
		else if (r < 25)
			n = MAX_TERMS;
		else if (r < 80)
			n = $urandom_range(1, MAX_TERMS - 1);
		else
			n = $urandom_range(MAX_TERMS + 1, (1 << CNT_W) - 1);
		return mk_item(rand_angle(), n);
	endfunction

	// Offer one beat after an optional idle gap and hold it until accepted.
	// With a zero gap valid simply stays high into the next beat.
	task automatic send_item(input in_item_t item, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
		if (item.term_count == 0)
			zero_counts++;
		if (item.term_count > MAX_TERMS)
			over_counts++;
	endtask

	task automatic run_random(input int n, input bit idle);
		repeat (n)
			send_item(rand_item(), idle ? pick_gap() : 0);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	// Pending is registered in the checker, so let a clock edge pass before reading it.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Output side: random stalls, one long hold on request, and gap-free
	// stretches while no_idle is set.
	initial begin : result_sink
		int stall;
		int run;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (stall_burst && !burst_served) begin
				out_ready    <= 1'b0;
				burst_active <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				burst_served <= 1'b1;
			end
			stall = no_idle ? 0 : pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = no_idle ? 32 : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero count, single term, full count, over-range counts,
		// both ends of the angle range, +-1.0, +-pi, and patterned bits.
		send_item(mk_item(32'h0, 0), 0);
		send_item(mk_item(32'h0, MAX_TERMS), pick_gap());
		send_item(mk_item(X_ONE, 1), pick_gap());
		send_item(mk_item(X_ONE, MAX_TERMS), pick_gap());
		send_item(mk_item(-X_ONE, MAX_TERMS), pick_gap());
		send_item(mk_item(X_PI, MAX_TERMS), pick_gap());
		send_item(mk_item(-X_PI, 8), pick_gap());
		send_item(mk_item(X_MAX, MAX_TERMS), pick_gap());
		send_item(mk_item(X_MIN, MAX_TERMS), pick_gap());
		send_item(mk_item(X_MIN, 31), pick_gap());
		send_item(mk_item(X_MAX, MAX_TERMS + 1), pick_gap());
		send_item(mk_item(X_MIN, 0), pick_gap());
		send_item(mk_item(32'h0000_0001, 2), pick_gap());
		send_item(mk_item(32'hFFFF_FFFF, MAX_TERMS), pick_gap());
		send_item(mk_item(32'h5555_5555, 5), pick_gap());
		send_item(mk_item(32'hAAAA_AAAA, 12), pick_gap());
		send_item(mk_item(32'h4000_0000, 3), pick_gap());
		send_item(mk_item(32'h2000_0001, 15), pick_gap());
		send_item(mk_item(32'hC000_0000, 20), pick_gap());
		send_item(mk_item(X_HALF_PI, 10), pick_gap());

		// Pause the sender until the pipeline is empty.
		wait_drained();

		run_random(300, 1'b1);
		wait_drained();

		// Hold the output off for a long stretch and keep offering beats
		// back to back, so the block fills and drops in_ready.
		stall_burst <= 1'b1;
		@(posedge clk);
		while (!burst_active)
			@(posedge clk);
		repeat (20)
			send_item(rand_item(), 0);
		while (!burst_served)
			@(posedge clk);
		stall_burst <= 1'b0;

		// Gap-free streaming on both sides.
		no_idle <= 1'b1;
		run_random(150, 1'b0);
		no_idle <= 1'b0;

		run_random(360, 1'b1);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d input beats, %0d result beats checked, %0d zero-count, %0d %s",
			beats_sent, checked, zero_counts, over_counts, "over-range count");
		$display("Summary: %s, %s",
			"angle extremes, random Q4.28 angles, long output hold with input backpressure",
			"back-to-back streaming");
		if (mismatches == 0) begin
			$display("tb_cosine_taylor_partial_sum: done, clean");
		end else begin
			$display("tb_cosine_taylor_partial_sum: done, errors");
		end
		$finish;
	end

endmodule
